// ----- design/bbd_pkg.sv -----
`default_nettype none
package bbd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_RATIO  = 16;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = 10;
  localparam int SUB_W   = $clog2(MAX_RATIO);
  localparam int RATIO_W = 5;
  localparam int DIM_W   = 11;
  localparam int PIX_W   = 8;
  localparam int CIDX_W  = 2;

  localparam logic [RATIO_W-1:0] RATIO_RST  = 5'd2;
  localparam logic [DIM_W-1:0]   WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0]   HEIGHT_RST = 11'd480;

  localparam logic [1:0]       CNT_SAT = 2'd2;
  localparam logic [PIX_W-1:0] PIX_ON  = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_OFF = 8'h00;

  typedef enum logic [CIDX_W-1:0] {
    REG_RATIO  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
  } cfg_t;

  typedef struct packed {
    logic             active;
    logic             first;
    logic             seg_start;
    logic             seg_end;
    logic             last;
    logic             frame_last;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } scan_t;

endpackage
`default_nettype wire

// ----- design/bbd_cfg.sv -----
`default_nettype none
module bbd_cfg
  import bbd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]  cfg_data,
  output cfg_t                   cfg,
  output logic                   restart
);

  logic [RATIO_W-1:0] r_in;
  logic [DIM_W-1:0]   d_in, h_in;

  always_comb begin
    r_in = cfg_data[RATIO_W-1:0];
    if (r_in == '0) begin
      r_in = RATIO_W'(1);
    end else if (r_in > RATIO_W'(MAX_RATIO)) begin
      r_in = RATIO_W'(MAX_RATIO);
    end
    d_in = cfg_data;
    if (d_in == '0) begin
      d_in = DIM_W'(1);
    end else if (d_in > DIM_W'(MAX_WIDTH)) begin
      d_in = DIM_W'(MAX_WIDTH);
    end
    h_in = cfg_data;
    if (h_in == '0) begin
      h_in = DIM_W'(1);
    end else if (h_in > DIM_W'(MAX_HEIGHT)) begin
      h_in = DIM_W'(MAX_HEIGHT);
    end
  end

  always_comb begin
    case (cfg_index)
      REG_RATIO, REG_WIDTH, REG_HEIGHT: restart = cfg_valid;
      default: restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ratio  <= RATIO_RST;
      cfg.width  <= WIDTH_RST;
      cfg.height <= HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RATIO:  cfg.ratio  <= r_in;
        REG_WIDTH:  cfg.width  <= d_in;
        REG_HEIGHT: cfg.height <= h_in;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/bbd_scan.sv -----
`default_nettype none
module bbd_scan
  import bbd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic restart,
  input  wire logic step,
  output scan_t     scan
);

  logic [ROW_W-1:0] in_col, in_row;
  logic [SUB_W-1:0] sub_col, sub_row;
  logic [DIM_W-1:0] block_col, block_row;
  logic [DIM_W-1:0] blk_x0, blk_y0;

  logic [DIM_W:0]   x_end, y_end, x_end2, y_end2;
  logic [RATIO_W-1:0] sc1, sr1;
  logic [DIM_W-1:0] ic1, ir1;
  logic col_ok, row_ok, col_wrap, row_wrap;

  always_comb begin
    x_end  = {1'b0, blk_x0} + (DIM_W+1)'(cfg.ratio);
    y_end  = {1'b0, blk_y0} + (DIM_W+1)'(cfg.ratio);
    x_end2 = x_end + (DIM_W+1)'(cfg.ratio);
    y_end2 = y_end + (DIM_W+1)'(cfg.ratio);
    col_ok = x_end <= {1'b0, cfg.width};
    row_ok = y_end <= {1'b0, cfg.height};
    sc1    = {1'b0, sub_col} + RATIO_W'(1);
    sr1    = {1'b0, sub_row} + RATIO_W'(1);
    ic1    = {1'b0, in_col} + DIM_W'(1);
    ir1    = {1'b0, in_row} + DIM_W'(1);
    col_wrap = ic1 >= cfg.width;
    row_wrap = ir1 >= cfg.height;

    scan.active     = col_ok && row_ok;
    scan.seg_start  = sub_col == '0;
    scan.seg_end    = sc1 == cfg.ratio;
    scan.first      = scan.seg_start && sub_row == '0;
    scan.last       = scan.seg_end && sr1 == cfg.ratio;
    scan.frame_last = x_end2 > {1'b0, cfg.width} && y_end2 > {1'b0, cfg.height};
    scan.col        = block_col[COL_W-1:0];
    scan.row        = block_row[ROW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col    <= '0;
      in_row    <= '0;
      sub_col   <= '0;
      sub_row   <= '0;
      block_col <= '0;
      block_row <= '0;
      blk_x0    <= '0;
      blk_y0    <= '0;
    end else if (step) begin
      if (scan.active) begin
        if (scan.seg_end) begin
          sub_col   <= '0;
          block_col <= block_col + DIM_W'(1);
          blk_x0    <= x_end[DIM_W-1:0];
        end else begin
          sub_col <= sc1[SUB_W-1:0];
        end
      end
      if (col_wrap) begin
        in_col    <= '0;
        sub_col   <= '0;
        block_col <= '0;
        blk_x0    <= '0;
        if (row_wrap) begin
          in_row    <= '0;
          sub_row   <= '0;
          block_row <= '0;
          blk_y0    <= '0;
        end else begin
          in_row <= ir1[ROW_W-1:0];
          if (sr1 >= cfg.ratio) begin
            sub_row   <= '0;
            block_row <= block_row + DIM_W'(1);
            blk_y0    <= y_end[DIM_W-1:0];
          end else begin
            sub_row <= sr1[SUB_W-1:0];
          end
        end
      end else begin
        in_col <= ic1[ROW_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/bbd_count.sv -----
`default_nettype none
module bbd_count
  import bbd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             take,
  input  wire scan_t            scan,
  input  wire logic [PIX_W-1:0] pixel,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [PIX_W-1:0]      out_pixel,
  output logic [ROW_W-1:0]      out_row,
  output logic [COL_W-1:0]      out_col,
  output logic                  frame_last
);

  logic [1:0] mem [MAX_WIDTH];

  logic             a_valid;
  scan_t            a;
  logic             a_set;
  logic [1:0]       rd_data;
  logic             lw_valid;
  logic [COL_W-1:0] lw_idx;
  logic [1:0]       lw_data;
  logic [1:0]       acc;

  logic [1:0] base, cnt;
  logic       emit, go;

  always_comb begin
    if (a.first) begin
      base = '0;
    end else if (a.seg_start) begin
      base = (lw_valid && lw_idx == a.col) ? lw_data : rd_data;
    end else begin
      base = acc;
    end
    cnt  = (a_set && base != CNT_SAT) ? base + 2'd1 : base;
    emit = a_valid && a.active && a.last;
    go   = a_valid && (!emit || !out_valid || out_ready);
    in_ready = !a_valid || go;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rd_data <= mem[scan.col];
    end
    if (go && a.active && a.seg_end) begin
      mem[a.col] <= cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a     <= scan;
      a_set <= pixel != '0;
    end
    if (go && a.active) begin
      acc <= cnt;
    end
    if (go && a.active && a.seg_end) begin
      lw_idx  <= a.col;
      lw_data <= cnt;
    end
    if (go && emit) begin
      out_pixel  <= (cnt >= CNT_SAT) ? PIX_ON : PIX_OFF;
      out_row    <= a.row;
      out_col    <= a.col;
      frame_last <= a.frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
      lw_valid  <= 1'b0;
    end else begin
      if (take) begin
        a_valid <= 1'b1;
      end else if (go) begin
        a_valid <= 1'b0;
      end
      if (go && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (go && a.active && a.seg_end) begin
        lw_valid <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/binary_block_downsampler.sv -----
// channel  valid      ready      payload
// in       in_valid   in_ready   pixel
// out      out_valid  out_ready  out_pixel, out_row, out_col, frame_last
// cfg      cfg_valid  cfg_ready  cfg_index, cfg_data
//
// One pixel per cycle unless a held output stalls. A beat is registered in the
// input stage, then the block result lands in the output register.
// Line store: one 2-bit count per block column, read when the beat is taken,
// last write forwarded. Reset and any register write restart the frame.
// cfg_ready is always high. A held output stalls input only on a block end.
`default_nettype none
module binary_block_downsampler
  import bbd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [PIX_W-1:0]  pixel,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [PIX_W-1:0]       out_pixel,
  output logic [ROW_W-1:0]       out_row,
  output logic [COL_W-1:0]       out_col,
  output logic                   frame_last,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]  cfg_data
);

  cfg_t  cfg;
  scan_t scan;
  logic  restart;
  logic  take;

  assign cfg_ready = 1'b1;
  assign take      = in_valid && in_ready;

  bbd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .restart   (restart)
  );

  bbd_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .restart (restart),
    .step    (take),
    .scan    (scan)
  );

  bbd_count u_count (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .scan       (scan),
    .pixel      (pixel),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_pixel  (out_pixel),
    .out_row    (out_row),
    .out_col    (out_col),
    .frame_last (frame_last)
  );

  a_stall_only_on_full_out: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held result");

  a_pixel_binary: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_pixel == PIX_ON || out_pixel == PIX_OFF)
    else $error("result pixel not binary");

  a_ratio_one_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && cfg.ratio == RATIO_W'(1) |-> out_pixel == PIX_OFF)
    else $error("single-pixel block reported set");

endmodule
`default_nettype wire
